>>> rtl/kbcu_pkg.sv
// ----------------------------------------------------------------------------
// kbcu_pkg
// Shared types, constants and helpers for the k-bit chunk unpacker.
// ----------------------------------------------------------------------------
package kbcu_pkg;

  localparam int BYTE_W   = 8;
  localparam int WIDTH_W  = 4;
  localparam int LO_W     = 7;   // leftover bits held between bytes
  localparam int LO_CNT_W = 3;
  localparam int ACC_W    = 15;  // leftover plus one new byte
  localparam int NBITS_W  = 4;

  localparam logic [WIDTH_W-1:0] CHUNK_WIDTH_RESET = 4'd1;
  localparam logic [WIDTH_W-1:0] CHUNK_WIDTH_MIN   = 4'd1;
  localparam logic [WIDTH_W-1:0] CHUNK_WIDTH_MAX   = 4'd8;

  // register index, taken from the word address
  localparam logic REG_CHUNK_WIDTH = 1'b0;

  // one queued request
  typedef struct packed {
    logic [BYTE_W-1:0] msg_byte;
    logic              last_byte;
  } q_item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [WIDTH_W-1:0] k;      // effective chunk width, 1..8
    logic               clear;  // drop leftover bits
  } cfg_ctl_t;

  // queue head towards the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    if (w < CHUNK_WIDTH_MIN) begin
      r = CHUNK_WIDTH_MIN;
    end else if (w > CHUNK_WIDTH_MAX) begin
      r = CHUNK_WIDTH_MAX;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

>>> rtl/k_bit_chunk_unpacker.sv
// ----------------------------------------------------------------------------
// k_bit_chunk_unpacker
// LSB-first byte to k-bit chunk gearbox with APB-style width register.
// ----------------------------------------------------------------------------
// Message bytes enter through a two-entry queue and are cut into chunks of
// chunk_width bits (1 to 8, out-of-range values clamp), oldest bit first.
// The gearbox shift register produces one chunk per cycle while the output
// register is free or being read. A byte yields ceil((leftover + 8) / width)
// chunks if it is the last byte of a message, floor((leftover + 8) / width)
// otherwise: one chunk per byte at width 8, eight at width 1. New bytes
// are accepted while earlier chunks are still being produced or wait in the
// output register. The final chunk of a message carries out_tlast; a short
// remainder goes out zero-extended. Writing chunk_width drops any leftover
// bits and must only happen while the block is idle. No clearing pass.
// ----------------------------------------------------------------------------
module k_bit_chunk_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] chunk
  output logic        out_tlast,  // chunk_last
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import kbcu_pkg::*;

  cfg_ctl_t cfg_ctl;
  q_item_t  in_item;
  q_head_t  head;
  logic     pop;

  assign in_item.msg_byte  = in_tdata;
  assign in_item.last_byte = in_tlast;

  kbcu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_ctl (cfg_ctl)
  );

  kbcu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  kbcu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ctl   (cfg_ctl),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_chunk (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

>>> rtl/kbcu_regs.sv
// ----------------------------------------------------------------------------
// kbcu_regs
// APB-style register port holding the chunk width.
// ----------------------------------------------------------------------------
module kbcu_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output kbcu_pkg::cfg_ctl_t    cfg_ctl
);
  import kbcu_pkg::*;

  logic [WIDTH_W-1:0] chunk_width_r;
  logic [WIDTH_W-1:0] chunk_width_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CHUNK_WIDTH);

  always_comb begin
    chunk_width_nxt = chunk_width_r;
    if (wr_en) begin
      chunk_width_nxt = pwdata[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_width_r <= CHUNK_WIDTH_RESET;
    end else begin
      chunk_width_r <= chunk_width_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_CHUNK_WIDTH) begin
      prdata = {{(32-WIDTH_W){1'b0}}, chunk_width_r};
    end
  end

  assign cfg_ctl.k     = eff_width(chunk_width_r);
  assign cfg_ctl.clear = wr_en;

endmodule

>>> rtl/kbcu_front.sv
// ----------------------------------------------------------------------------
// kbcu_front
// Accepts message bytes into a two-entry queue ahead of the gearbox.
// ----------------------------------------------------------------------------
module kbcu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kbcu_pkg::q_item_t  in_item,
  output kbcu_pkg::q_head_t  head,
  input  logic               pop
);
  import kbcu_pkg::*;

  q_item_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> rtl/kbcu_back.sv
// ----------------------------------------------------------------------------
// kbcu_back
// Gearbox: splits queued bytes into chunks, one chunk per cycle while the
// output register is free or being read; chunks go into that register.
// ----------------------------------------------------------------------------
module kbcu_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kbcu_pkg::cfg_ctl_t        cfg_ctl,
  input  kbcu_pkg::q_head_t         head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kbcu_pkg::BYTE_W-1:0] out_chunk,
  output logic                      out_last
);
  import kbcu_pkg::*;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [NBITS_W-1:0] n_r, n_nxt;
  logic               last_r, last_nxt;
  logic               busy_r, busy_nxt;
  logic               ov_r, ov_nxt;
  logic [BYTE_W-1:0]  od_r, od_nxt;
  logic               ol_r, ol_nxt;

  logic [WIDTH_W-1:0] k;
  logic [BYTE_W-1:0]  mask;
  logic               emit_ok;
  logic               has_full;
  logic [NBITS_W-1:0] n_after;
  logic [ACC_W-1:0]   acc_after;
  logic               more;
  logic               done;
  logic               load;
  logic [LO_W-1:0]    lo_bits;
  logic [LO_CNT_W-1:0] lo_cnt;

  assign k    = cfg_ctl.k;
  assign mask = 8'hFF >> (4'd8 - k);

  assign emit_ok   = busy_r && (!ov_r || out_ready);
  assign has_full  = (n_r >= k);
  assign n_after   = has_full ? (n_r - k) : '0;
  assign acc_after = acc_r >> k;
  // another chunk follows: a full one, or a partial one on the last byte
  assign more      = (n_after >= k) || (last_r && (n_after != '0));
  assign done      = emit_ok && !more;
  assign load      = head.valid && (!busy_r || done) && !cfg_ctl.clear;
  assign pop       = load;

  always_comb begin
    if (busy_r) begin
      lo_bits = last_r ? '0 : acc_after[LO_W-1:0];
      lo_cnt  = last_r ? '0 : n_after[LO_CNT_W-1:0];
    end else begin
      lo_bits = acc_r[LO_W-1:0];
      lo_cnt  = n_r[LO_CNT_W-1:0];
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    n_nxt    = n_r;
    last_nxt = last_r;
    busy_nxt = busy_r;
    if (cfg_ctl.clear) begin
      acc_nxt  = '0;
      n_nxt    = '0;
      last_nxt = 1'b0;
      busy_nxt = 1'b0;
    end else if (load) begin
      acc_nxt  = {{(ACC_W-LO_W){1'b0}}, lo_bits}
               | ({{(ACC_W-BYTE_W){1'b0}}, head.item.msg_byte} << lo_cnt);
      n_nxt    = {1'b0, lo_cnt} + 4'd8;
      last_nxt = head.item.last_byte;
      busy_nxt = 1'b1;
    end else if (done) begin
      acc_nxt  = {{(ACC_W-LO_W){1'b0}}, lo_bits};
      n_nxt    = {1'b0, lo_cnt};
      busy_nxt = 1'b0;
    end else if (emit_ok) begin
      acc_nxt = acc_after;
      n_nxt   = n_after;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    ol_nxt = ol_r;
    if (emit_ok) begin
      ov_nxt = 1'b1;
      od_nxt = acc_r[BYTE_W-1:0] & mask;
      ol_nxt = last_r && (n_after == '0);
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      n_r    <= '0;
      last_r <= 1'b0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      n_r    <= n_nxt;
      last_r <= last_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_chunk = od_r;
  assign out_last  = ol_r;

  // a freshly loaded byte always holds at least eight bits
  a_load_bits: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && (n_r >= 4'd8)))
    else $error("loaded byte without eight bits");

  // a busy gearbox short of a full chunk must owe a final partial one
  a_partial_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !has_full) |-> (last_r && (n_r != '0)))
    else $error("busy with nothing to emit");

  // leftover between bytes is always shorter than one chunk
  a_leftover_short: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (n_r < k))
    else $error("leftover not shorter than a chunk");

  // every emitted chunk lands in the output register
  a_emit_reg: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ok |=> ov_r)
    else $error("emitted chunk lost");

endmodule
